// ===== design/projected_sor_obstacle_solver_macros.svh =====
// Assertion macros used by the checker file of the solver.
`ifndef PROJECTED_SOR_OBSTACLE_SOLVER_MACROS_SVH
`define PROJECTED_SOR_OBSTACLE_SOLVER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PSOR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PSOR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/psor_pkg.sv =====
package psor_pkg;

	// Fixed field widths.
	localparam int VAL_W   = 32;
	localparam int OMEGA_W = 26;
	localparam int TOL_W   = 31;
	localparam int NODES_W = 5;
	localparam int COUNT_W = 16;
	localparam int INDEX_W = 4;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OMEGA    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NODES    = 3'd4;

	// Register values after reset.
	localparam logic signed [VAL_W-1:0] RST_OBSTACLE = 32'sd16777216;
	localparam logic signed [VAL_W-1:0] RST_SOURCE   = 32'sd1092267;
	localparam logic [OMEGA_W-1:0]      RST_OMEGA    = 26'd30198989;
	localparam logic [TOL_W-1:0]        RST_TOL      = 31'd168;
	localparam logic [NODES_W-1:0]      RST_NODES    = 5'd15;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT,
		ST_ROTATE
	} psor_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic mult;
		logic commit;
		logic rotate;
	} psor_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic node_last;
		logic rot_done;
	} psor_status_t;

endpackage

// ===== design/psor_in_if.sv =====
interface psor_in_if;
	logic valid;
	logic ready;
	logic start_fresh;

	modport source (output valid, output start_fresh, input ready);
	modport sink (input valid, input start_fresh, output ready);
endinterface

// ===== design/psor_out_if.sv =====
interface psor_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  node_index;
	logic signed [31:0] node_value;
	logic [30:0] max_change;
	logic [15:0] sweep_count;
	logic        converged;
	logic        last;

	modport source (output valid, output node_index, output node_value, output max_change,
		output sweep_count, output converged, output last, input ready);
	modport sink (input valid, input node_index, input node_value, input max_change,
		input sweep_count, input converged, input last, output ready);
endinterface

// ===== design/psor_ctrl.sv =====
module psor_ctrl
	import psor_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  psor_status_t status,
	output psor_cmd_t    cmd
);

	psor_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.mult = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					if (!status.node_last) begin
						state_d = ST_CALC;
					end else if (status.rot_done) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_ROTATE;
					end
				end
			end
			ST_ROTATE: begin
				cmd.rotate = 1'b1;
				if (status.rot_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/psor_datapath.sv =====
module psor_datapath
	import psor_pkg::*;
#(
	parameter int MAX_NODES = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	input  logic                 start_fresh,
	input  psor_cmd_t            cmd,
	output psor_status_t         status,
	psor_out_if.source           out_ch
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam logic [IDX_W-1:0] IDX_END = IDX_W'(MAX_NODES - 1);
	localparam logic signed [37:0] MIN_VAL = -38'sd2147483648;
	localparam logic signed [60:0] HALF_LSB = 61'sd8388608;

	// Configuration registers.
	logic signed [VAL_W-1:0] obstacle_q;
	logic signed [VAL_W-1:0] source_q;
	logic [OMEGA_W-1:0]      omega_q;
	logic [TOL_W-1:0]        tol_q;
	logic [NODES_W-1:0]      nodes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obstacle_q <= RST_OBSTACLE;
			source_q   <= RST_SOURCE;
			omega_q    <= RST_OMEGA;
			tol_q      <= RST_TOL;
			nodes_q    <= RST_NODES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OBSTACLE: obstacle_q <= $signed(cfg_data);
				REG_SOURCE:   source_q   <= $signed(cfg_data);
				REG_OMEGA:    omega_q    <= cfg_data[OMEGA_W-1:0];
				REG_TOL:      tol_q      <= cfg_data[TOL_W-1:0];
				REG_NODES:    nodes_q    <= cfg_data[NODES_W-1:0];
				default: ;
			endcase
		end
	end

	// Index of the last swept node, with the node count clamped to its range.
	logic [IDX_W-1:0] last_idx;
	always_comb begin
		if (nodes_q < 5'd3) begin
			last_idx = IDX_W'(2);
		end else if (int'(nodes_q) > MAX_NODES) begin
			last_idx = IDX_END;
		end else begin
			last_idx = IDX_W'(nodes_q - 5'd1);
		end
	end

	// Sweep state: node counter, left neighbor, running maximum, sweep count.
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        last_q;
	logic signed [VAL_W-1:0] left_q;
	logic [TOL_W-1:0]        maxc_q;
	logic [COUNT_W-1:0]      count_q;
	logic signed [VAL_W-1:0] sol_q [MAX_NODES];
	logic signed [60:0]      prod_s1;

	// Current-node and right-neighbor taps of the rotating solution line.
	logic signed [VAL_W-1:0] u_val;
	logic signed [VAL_W-1:0] r_val;
	assign u_val = sol_q[0];
	assign r_val = (idx_q == last_q) ? '0 : sol_q[1];

	// Target value and its difference to the old value.
	logic signed [33:0] nb_sum;
	logic signed [32:0] ubar;
	logic signed [33:0] diff;
	logic signed [26:0] omega_s;
	assign nb_sum  = 34'(source_q) + 34'(left_q) + 34'(r_val);
	assign ubar    = $signed(nb_sum[33:1]);
	assign diff    = 34'(ubar) - 34'(u_val);
	assign omega_s = $signed({1'b0, omega_q});

	// Rounding, clamping and the change of one node.
	logic signed [60:0]      rnd;
	logic signed [36:0]      step;
	logic signed [37:0]      relaxed;
	logic signed [VAL_W-1:0] nv;
	logic signed [32:0]      ch;
	logic [32:0]             ch_mag;
	logic [TOL_W-1:0]        ch_sat;
	logic [TOL_W-1:0]        maxc_new;
	always_comb begin
		rnd     = prod_s1 + HALF_LSB;
		step    = $signed(rnd[60:24]);
		relaxed = 38'(u_val) + 38'(step);
		if (38'(obstacle_q) <= relaxed) begin
			nv = obstacle_q;
		end else if (relaxed < MIN_VAL) begin
			nv = MIN_VAL[VAL_W-1:0];
		end else begin
			nv = relaxed[VAL_W-1:0];
		end
		ch     = 33'(nv) - 33'(u_val);
		ch_mag = ch[32] ? 33'(-ch) : 33'(ch);
		ch_sat = (ch_mag[32:31] != 2'b00) ? {TOL_W{1'b1}} : ch_mag[TOL_W-1:0];
		maxc_new = (ch_sat > maxc_q) ? ch_sat : maxc_q;
	end

	// Multiplier stage.
	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_s1 <= 61'(omega_s) * 61'(diff);
		end
	end

	// Solution line: rotates by one slot per committed or skipped node.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_NODES; k++) begin
				sol_q[k] <= '0;
			end
		end else if (cmd.start && start_fresh) begin
			for (int k = 0; k < MAX_NODES; k++) begin
				sol_q[k] <= '0;
			end
		end else if (cmd.commit || cmd.rotate) begin
			for (int k = 0; k < MAX_NODES - 1; k++) begin
				sol_q[k] <= sol_q[k+1];
			end
			sol_q[MAX_NODES-1] <= cmd.commit ? nv : sol_q[0];
		end
	end

	// Sweep control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			last_q  <= '0;
			left_q  <= '0;
			maxc_q  <= '0;
			count_q <= '0;
		end else if (cmd.start) begin
			idx_q  <= '0;
			last_q <= last_idx;
			left_q <= '0;
			maxc_q <= '0;
			if (start_fresh) begin
				count_q <= COUNT_W'(1);
			end else if (count_q != {COUNT_W{1'b1}}) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end else if (cmd.commit) begin
			idx_q  <= idx_q + IDX_W'(1);
			left_q <= nv;
			maxc_q <= maxc_new;
		end else if (cmd.rotate) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Output register; a new result is loaded only when the slot is free.
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic               fin;
	logic [INDEX_W-1:0] oidx_q;
	logic [VAL_W-1:0]   oval_q;
	logic [TOL_W-1:0]   omax_q;
	logic [COUNT_W-1:0] ocnt_q;
	logic               oconv_q;
	logic               olast_q;
	assign fin = (idx_q == last_q);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			oidx_q  <= INDEX_W'(idx_q);
			oval_q  <= nv;
			omax_q  <= fin ? maxc_new : '0;
			ocnt_q  <= count_q;
			oconv_q <= fin && (maxc_new <= tol_q);
			olast_q <= fin;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.node_index  = oidx_q;
	assign out_ch.node_value  = oval_q;
	assign out_ch.max_change  = omax_q;
	assign out_ch.sweep_count = ocnt_q;
	assign out_ch.converged   = oconv_q;
	assign out_ch.last        = olast_q;

	// Status to the controller.
	assign status.out_free  = !out_valid_q || out_ch.ready;
	assign status.node_last = fin;
	assign status.rot_done  = (idx_q == IDX_END);

endmodule

// ===== design/projected_sor_obstacle_solver.sv =====
// Projected SOR sweep engine for the 1D obstacle problem, Q8.24 values.
// Input channel in_ch: each accepted request runs one sweep over the interior
// nodes; start_fresh set clears the solution and the sweep count first.
// Output channel out_ch: one result per swept node in index order, with the
// node value and the updated sweep count; the last result carries the largest
// change, the converged flag and last set.
// Configuration: write cfg_data to register cfg_index while cfg_we is high,
// only between sweeps (0 obstacle, 1 source, 2 omega, 3 tolerance, 4 nodes).
// Each node runs through the states CALC and EMIT, since the left neighbor feeds the
// multiplier and its registered product feeds the clamp of the next value.
// After the last node of a sweep, the ROTATE state turns the solution shift line
// back into place when the sweep did not cover every slot. A first result passes
// the multiplier register and then the output register, where it is offered.
// A stalled receiver holds the sweep at the next node until the output
// register frees up; no result is dropped. in_ch.ready is high only between
// sweeps. Reset clears the solution, the sweep count and the registers to
// their defaults; the block is ready in the first cycle after reset.
module projected_sor_obstacle_solver
	import psor_pkg::*;
#(
	parameter int MAX_NODES = 16
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	psor_in_if.sink              in_ch,
	psor_out_if.source           out_ch
);

	psor_cmd_t    cmd;
	psor_status_t status;
	logic         in_ready;

	assign in_ch.ready = in_ready;

	// Sweep sequencer.
	psor_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Node arithmetic, solution line and output register.
	psor_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start_fresh (in_ch.start_fresh),
		.cmd         (cmd),
		.status      (status),
		.out_ch      (out_ch)
	);

endmodule

// ===== design/psor_checker.sv =====
`include "projected_sor_obstacle_solver_macros.svh"

module psor_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_last,
	input logic        out_converged,
	input logic [30:0] out_max_change,
	input logic [15:0] out_sweep_count
);

	// A result that is not taken stays offered.
	`PSOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// A new request is not taken in the cycle right after one was accepted.
	`PSOR_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken mid-sweep")

	// Every result belongs to a sweep that has been counted.
	`PSOR_ASSERT_NOW(a_count_nonzero, out_valid, out_sweep_count != 16'd0, "sweep count is zero")

	// Change and convergence are reported only on the last result.
	`PSOR_ASSERT_NOW(a_summary_last, out_valid && !out_last,
		out_max_change == 31'd0 && !out_converged, "summary fields set before last")

endmodule

bind projected_sor_obstacle_solver psor_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_last        (out_ch.last),
	.out_converged   (out_ch.converged),
	.out_max_change  (out_ch.max_change),
	.out_sweep_count (out_ch.sweep_count)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import psor_pkg::*;

	localparam int MAX_NODES = 16;
	localparam int RESET_CYCLES = 12;
	// Longest stretch of a sweep after its last result: the shift line rotation plus margin.
	localparam int DRAIN_CYCLES = 2 * MAX_NODES + 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_SWEEPS = 20;
	localparam int TAIL_SWEEPS = 20;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [OMEGA_W-1:0] OMEGA_MAX = '1;
	localparam logic [TOL_W-1:0] TOL_MAX = '1;
	localparam longint CHANGE_CAP = 64'sd2147483647;
	localparam longint VAL_FLOOR = -64'sd2147483648;

	typedef struct packed {
		logic [INDEX_W-1:0]      node_index;
		logic signed [VAL_W-1:0] node_value;
		logic [TOL_W-1:0]        max_change;
		logic [COUNT_W-1:0]      sweep_count;
		logic                    converged;
		logic                    last;
	} node_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0] cfg_data;

	psor_in_if  in_ch();
	psor_out_if out_ch();

	projected_sor_obstacle_solver #(
		.MAX_NODES(MAX_NODES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Our own copy of the register file and of the mesh state.
	logic signed [VAL_W-1:0] obstacle_cfg;
	logic signed [VAL_W-1:0] source_cfg;
	logic [OMEGA_W-1:0]      omega_cfg;
	logic [TOL_W-1:0]        tol_cfg;
	logic [NODES_W-1:0]      nodes_cfg;
	logic signed [VAL_W-1:0] mesh [MAX_NODES];
	logic [COUNT_W-1:0]      sweep_total;

	node_result_t expected_nodes[$];

	bit jitter = 1'b1;
	int failures = 0;
	int sweeps_sent = 0;
	int results_seen = 0;
	int converged_seen = 0;
	int reg_writes = 0;
	int quiet_cycles;

	always #1 clk = ~clk;

	// Computes one projected SOR sweep on the local mesh and queues the node results.
	task automatic run_sor_sweep(input bit fresh);
		int n;
		longint u;
		longint lft;
		longint rgt;
		longint ubar;
		longint prod;
		longint relaxed;
		longint nv;
		longint chg;
		longint maxc;
		node_result_t res;
		n = int'(nodes_cfg);
		if (n < 3) begin
			n = 3;
		end
		if (n > MAX_NODES) begin
			n = MAX_NODES;
		end
		if (fresh) begin
			foreach (mesh[k]) begin
				mesh[k] = '0;
			end
			sweep_total = '0;
		end
		maxc = 0;
		// Gauss-Seidel order: the left neighbor already holds its new value.
		for (int i = 0; i < n; i++) begin
			u = longint'(mesh[i]);
			lft = (i > 0) ? longint'(mesh[i-1]) : 64'sd0;
			rgt = (i < n - 1) ? longint'(mesh[i+1]) : 64'sd0;
			ubar = (longint'(source_cfg) + lft + rgt) >>> 1;
			prod = longint'(omega_cfg) * (ubar - u);
			relaxed = u + ((prod + (longint'(1) << 23)) >>> 24);
			if (longint'(obstacle_cfg) <= relaxed) begin
				nv = longint'(obstacle_cfg);
			end else if (relaxed < VAL_FLOOR) begin
				nv = VAL_FLOOR;
			end else begin
				nv = relaxed;
			end
			chg = nv - u;
			if (chg < 0) begin
				chg = -chg;
			end
			if (chg > CHANGE_CAP) begin
				chg = CHANGE_CAP;
			end
			if (chg > maxc) begin
				maxc = chg;
			end
			mesh[i] = nv[VAL_W-1:0];
		end
		if (sweep_total != COUNT_MAX) begin
			sweep_total++;
		end
		// Only the closing result carries the change, the flag and last.
		for (int i = 0; i < n; i++) begin
			res.node_index = INDEX_W'(i);
			res.node_value = mesh[i];
			res.last = (i == n - 1);
			res.max_change = res.last ? maxc[TOL_W-1:0] : '0;
			res.sweep_count = sweep_total;
			res.converged = res.last && (maxc <= longint'(tol_cfg));
			expected_nodes.push_back(res);
		end
	endtask

	// Writes one register and mirrors it in the local copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_OBSTACLE: obstacle_cfg = data;
			REG_SOURCE:   source_cfg = data;
			REG_OMEGA:    omega_cfg = data[OMEGA_W-1:0];
			REG_TOL:      tol_cfg = data[TOL_W-1:0];
			REG_NODES:    nodes_cfg = data[NODES_W-1:0];
			default: ;
		endcase
	endtask

	// Sends one sweep request, with an optional idle burst ahead of it.
	task automatic send_sweep(input bit fresh);
		// Registers change only between sweeps, so the write port is closed here.
		cfg_we <= 1'b0;
		if (jitter && $urandom_range(0, 2) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.start_fresh <= fresh;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		sweeps_sent++;
		run_sor_sweep(fresh);
	endtask

	// Lets every outstanding result arrive and the block settle back to idle.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_nodes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sweeps with the register values that reset leaves.
	task automatic test_reset_state();
		send_sweep(1'b0);
		send_sweep(1'b1);
		send_sweep(1'b0);
		send_sweep(1'b0);
	endtask

	// Node counts below three and above the mesh size are clamped.
	task automatic test_node_count();
		wait_drained();
		write_reg(REG_NODES, 32'hFFFF_FFE0);
		send_sweep(1'b1);
		wait_drained();
		write_reg(REG_NODES, 32'd2);
		send_sweep(1'b1);
		wait_drained();
		write_reg(REG_NODES, 32'd17);
		send_sweep(1'b1);
		wait_drained();
		write_reg(REG_NODES, 32'h0000_001F);
		send_sweep(1'b1);
		wait_drained();
		write_reg(REG_NODES, 32'd16);
		send_sweep(1'b1);
		send_sweep(1'b0);
	endtask

	// Extreme obstacle, source, omega and tolerance values, with saturation.
	task automatic test_value_extremes();
		wait_drained();
		write_reg(REG_OBSTACLE, VAL_MIN);
		write_reg(REG_SOURCE, VAL_MAX);
		send_sweep(1'b1);
		wait_drained();
		// Omega above two diverges downward until the value floor.
		write_reg(REG_OBSTACLE, VAL_MAX);
		write_reg(REG_SOURCE, VAL_MIN);
		write_reg(REG_OMEGA, {{(VAL_W-OMEGA_W){1'b1}}, OMEGA_MAX});
		send_sweep(1'b1);
		send_sweep(1'b0);
		send_sweep(1'b0);
		wait_drained();
		write_reg(REG_TOL, {1'b1, TOL_MAX});
		send_sweep(1'b0);
		wait_drained();
		// Zero omega leaves every node unchanged, so a zero tolerance is met.
		write_reg(REG_OMEGA, '0);
		write_reg(REG_TOL, '0);
		send_sweep(1'b0);
	endtask

	// Writes to unused register indexes must not disturb anything.
	task automatic test_unused_index();
		wait_drained();
		write_reg(REG_OBSTACLE, RST_OBSTACLE);
		write_reg(REG_SOURCE, RST_SOURCE);
		write_reg(REG_OMEGA, VAL_W'(RST_OMEGA));
		write_reg(REG_TOL, VAL_W'(RST_TOL));
		write_reg(REG_NODES, VAL_W'(RST_NODES));
		for (int k = int'(REG_NODES) + 1; k < (1 << CFG_IDX_W); k++) begin
			write_reg(CFG_IDX_W'(k), $urandom);
		end
		send_sweep(1'b1);
		send_sweep(1'b0);
	endtask

	// Phases of random register settings, each followed by a run of sweeps.
	task automatic test_random_sweeps(input int phases, input bit allow_jitter);
		logic [VAL_W-1:0] word;
		bit fresh;
		for (int p = 0; p < phases; p++) begin
			wait_drained();
			case ($urandom_range(0, 4))
				0: word = $urandom;
				1: word = $urandom_range(0, 1 << 26);
				2: word = '0 - VAL_W'($urandom_range(0, 1 << 25));
				3: word = VAL_MAX;
				default: word = VAL_MIN;
			endcase
			write_reg(REG_OBSTACLE, word);
			if ($urandom_range(0, 3) == 0) begin
				word = $urandom;
			end else begin
				word = VAL_W'($urandom_range(0, 1 << 22)) - VAL_W'(1 << 21);
			end
			write_reg(REG_SOURCE, word);
			word = $urandom;
			if ($urandom_range(0, 4) != 0) begin
				word[OMEGA_W-1:0] = OMEGA_W'($urandom_range(0, 1 << 25));
			end
			write_reg(REG_OMEGA, word);
			word = $urandom;
			case ($urandom_range(0, 3))
				0: word[TOL_W-1:0] = '0;
				1: word[TOL_W-1:0] = TOL_W'($urandom_range(0, 4096));
				2: word[TOL_W-1:0] = TOL_MAX;
				default: ;
			endcase
			write_reg(REG_TOL, word);
			word = $urandom;
			if ($urandom_range(0, 3) != 0) begin
				word[NODES_W-1:0] = NODES_W'($urandom_range(3, MAX_NODES));
			end
			write_reg(REG_NODES, word);
			jitter = allow_jitter && ($urandom_range(0, 3) != 0);
			// Mostly continued sweeps so the solution evolves, with the odd restart.
			for (int k = 0; k < PHASE_SWEEPS; k++) begin
				fresh = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0);
				send_sweep(fresh);
			end
		end
	endtask

	// A long run of continued sweeps on the smallest mesh, with no idle cycles.
	task automatic test_small_mesh();
		wait_drained();
		jitter = 1'b0;
		write_reg(REG_OBSTACLE, RST_OBSTACLE);
		write_reg(REG_SOURCE, RST_SOURCE);
		write_reg(REG_OMEGA, VAL_W'(RST_OMEGA));
		write_reg(REG_TOL, VAL_W'(RST_TOL));
		write_reg(REG_NODES, 32'd3);
		send_sweep(1'b1);
		repeat (TAIL_SWEEPS) send_sweep(1'b0);
	endtask

	// Result receiver: random stall bursts, otherwise always ready.
	always begin
		@(posedge clk);
		if (jitter && $urandom_range(0, 5) == 0) begin
			out_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		out_ch.ready <= 1'b1;
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
			failures++;
		end
	endfunction

	// Compare every accepted result with the oldest expected one.
	always @(posedge clk) begin
		node_result_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			results_seen++;
			if (out_ch.last === 1'b1 && out_ch.converged === 1'b1) begin
				converged_seen++;
			end
			if (expected_nodes.size() == 0) begin
				$error("result for node %0d arrived with nothing expected", out_ch.node_index);
				failures++;
			end else begin
				want = expected_nodes.pop_front();
				check_field("node_index", 32'(want.node_index), 32'(out_ch.node_index));
				check_field("node_value", want.node_value, out_ch.node_value);
				check_field("max_change", 32'(want.max_change), 32'(out_ch.max_change));
				check_field("sweep_count", 32'(want.sweep_count), 32'(out_ch.sweep_count));
				check_field("converged", 32'(want.converged), 32'(out_ch.converged));
				check_field("last", 32'(want.last), 32'(out_ch.last));
			end
		end
	end

	// Ends the run when no request, result or register write moves for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || cfg_we === 1'b1 ||
				(in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_OBSTACLE;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.start_fresh <= 1'b0;
		out_ch.ready <= 1'b0;
		obstacle_cfg = RST_OBSTACLE;
		source_cfg = RST_SOURCE;
		omega_cfg = RST_OMEGA;
		tol_cfg = RST_TOL;
		nodes_cfg = RST_NODES;
		foreach (mesh[k]) begin
			mesh[k] = '0;
		end
		sweep_total = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_node_count();
		test_value_extremes();
		test_unused_index();
		test_random_sweeps(7, 1'b1);
		test_random_sweeps(2, 1'b0);
		test_small_mesh();
		wait_drained();

		$display("Ran %0d sweep requests and checked %0d node results (%0d converged sweeps).",
			sweeps_sent, results_seen, converged_seen);
		$display("Applied %0d register writes, covering extremes, clamped node counts and unused indexes.",
			reg_writes);
		if (failures == 0 && expected_nodes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== projected_sor_obstacle_solver.f =====
+incdir+design
design/psor_pkg.sv
design/psor_in_if.sv
design/psor_out_if.sv
design/psor_ctrl.sv
design/psor_datapath.sv
design/projected_sor_obstacle_solver.sv
design/psor_checker.sv
tb/sv/tb_top.sv
